FILE: rtl/nsc_pkg.sv
// Package for the NMEA sentence checker: character codes, result kinds,
// field widths and the hex digit decoder. No dependencies.
package nsc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned DELAY_DEPTH = 4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam byte_t CH_DOLLAR = 8'h24;
	localparam byte_t CH_STAR   = 8'h2A;
	localparam byte_t CH_CR     = 8'h0D;
	localparam byte_t CH_LF     = 8'h0A;
	localparam byte_t CH_XON    = 8'h11;
	localparam byte_t CH_XOFF   = 8'h13;

	localparam byte_t MIN_LINE_LEN  = 8'd6;
	localparam byte_t COUNT_SAT     = 8'hFF;
	localparam byte_t MAX_LEN_RESET = 8'd127;

	localparam kind_t KIND_BODY      = 3'd0;
	localparam kind_t KIND_GOOD      = 3'd1;
	localparam kind_t KIND_BAD_FRAME = 3'd2;
	localparam kind_t KIND_BAD_HEX   = 3'd3;
	localparam kind_t KIND_MISMATCH  = 3'd4;
	localparam kind_t KIND_TOO_LONG  = 3'd5;
	localparam kind_t KIND_MARKER    = 3'd6;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	// uppercase hex digit only
	function automatic hex_t hex_decode(input byte_t c);
		hex_t h;
		h.ok    = 1'b0;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok    = 1'b1;
			h.value = c[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok    = 1'b1;
			h.value = c[3:0] + 4'd9;
		end
		return h;
	endfunction

endpackage

FILE: rtl/nsc_if.sv
// Valid/ready channel interfaces of the NMEA sentence checker.
// Depends on nsc_pkg.
interface nsc_rx_if;
	logic          valid;
	logic          ready;
	nsc_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_res_if;
	logic           valid;
	logic           ready;
	nsc_pkg::kind_t kind;
	nsc_pkg::byte_t payload_byte;
	nsc_pkg::byte_t computed_checksum;
	nsc_pkg::byte_t received_checksum;
	logic           last;

	modport source (output valid, output kind, output payload_byte,
		output computed_checksum, output received_checksum, output last,
		input ready);
	modport sink   (input valid, input kind, input payload_byte,
		input computed_checksum, input received_checksum, input last,
		output ready);
endinterface

FILE: rtl/nmea_sentence_checker.sv
// NMEA 0183 sentence checker. One received byte per rx transaction; zero or
// one result per byte on res. The block takes one byte every cycle while res
// is not stalled: a byte is registered, then checked against the line state
// combinationally and its result registered. Body bytes leave four bytes
// behind their arrival; the verdict comes with the line feed.
// Depends on nsc_pkg and nsc_if.
module nmea_sentence_checker (
	input  logic              clk,
	input  logic              arst_n,
	nsc_rx_if.sink            rx,
	nsc_res_if.source         res,
	input  logic              cfg_wr_en,
	input  nsc_pkg::byte_t    cfg_wr_data
);

	nsc_pkg::byte_t max_len_q;

	logic           valid_s1;
	nsc_pkg::byte_t byte_s1;

	logic           in_line_q;
	nsc_pkg::byte_t byte_count_q;
	logic           dollar_q;
	nsc_pkg::byte_t recent_q [nsc_pkg::DELAY_DEPTH];
	nsc_pkg::byte_t xor_q;
	logic           ovf_q;

	logic           out_valid_q;
	nsc_pkg::kind_t out_kind_q;
	nsc_pkg::byte_t out_payload_q;
	nsc_pkg::byte_t out_calc_q;
	nsc_pkg::byte_t out_rcvd_q;
	logic           out_last_q;

	logic           advance;

	logic           is_marker;
	logic           starting;
	nsc_pkg::byte_t cnt0, cnt1, xr0, xr_n;
	nsc_pkg::byte_t rb0 [nsc_pkg::DELAY_DEPTH];
	nsc_pkg::byte_t rb_n [nsc_pkg::DELAY_DEPTH];
	logic           dollar0, ovf1, in_line_n;
	nsc_pkg::hex_t  hx_hi, hx_lo;
	nsc_pkg::byte_t rcvd;

	logic           r_valid;
	nsc_pkg::kind_t r_kind;
	nsc_pkg::byte_t r_payload, r_calc, r_rcvd;
	logic           r_last;

	assign advance  = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_comb begin
		is_marker = !in_line_q && (byte_s1 == nsc_pkg::CH_XON || byte_s1 == nsc_pkg::CH_XOFF);
		starting  = !in_line_q && !is_marker;

		cnt0    = starting ? '0 : byte_count_q;
		dollar0 = starting ? (byte_s1 == nsc_pkg::CH_DOLLAR) : dollar_q;
		xr0     = starting ? '0 : xor_q;
		for (int i = 0; i < nsc_pkg::DELAY_DEPTH; i++) begin
			rb0[i] = starting ? '0 : recent_q[i];
		end

		cnt1 = (cnt0 < nsc_pkg::COUNT_SAT) ? cnt0 + 8'd1 : cnt0;
		ovf1 = (starting ? 1'b0 : ovf_q) || (cnt1 > max_len_q);

		hx_hi = nsc_pkg::hex_decode(rb0[1]);
		hx_lo = nsc_pkg::hex_decode(rb0[2]);
		rcvd  = (hx_hi.ok && hx_lo.ok) ? {hx_hi.value, hx_lo.value} : '0;

		rb_n      = rb0;
		xr_n      = xr0;
		in_line_n = 1'b1;
		r_valid   = 1'b0;
		r_kind    = nsc_pkg::KIND_BODY;
		r_payload = '0;
		r_calc    = '0;
		r_rcvd    = '0;
		r_last    = 1'b0;

		if (is_marker) begin
			in_line_n = 1'b0;
			r_valid   = 1'b1;
			r_kind    = nsc_pkg::KIND_MARKER;
			r_payload = byte_s1;
			r_last    = (byte_s1 == nsc_pkg::CH_XON);
		end else if (byte_s1 == nsc_pkg::CH_LF) begin
			in_line_n = 1'b0;
			r_valid   = 1'b1;
			r_calc    = xr0;
			r_rcvd    = rcvd;
			r_last    = 1'b1;
			if (ovf1) begin
				r_kind = nsc_pkg::KIND_TOO_LONG;
			end else if (cnt1 < nsc_pkg::MIN_LINE_LEN || !dollar0 ||
				rb0[0] != nsc_pkg::CH_STAR || rb0[3] != nsc_pkg::CH_CR) begin
				r_kind = nsc_pkg::KIND_BAD_FRAME;
			end else if (!hx_hi.ok || !hx_lo.ok) begin
				r_kind = nsc_pkg::KIND_BAD_HEX;
			end else if (xr0 != rcvd) begin
				r_kind = nsc_pkg::KIND_MISMATCH;
			end else begin
				r_kind = nsc_pkg::KIND_GOOD;
			end
		end else if (cnt1 != 8'd1) begin
			for (int i = 0; i < nsc_pkg::DELAY_DEPTH - 1; i++) begin
				rb_n[i] = rb0[i+1];
			end
			rb_n[nsc_pkg::DELAY_DEPTH-1] = byte_s1;
			if (cnt1 >= nsc_pkg::MIN_LINE_LEN) begin
				xr_n      = xr0 ^ rb0[0];
				r_valid   = 1'b1;
				r_payload = rb0[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= nsc_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q    <= 1'b0;
			byte_count_q <= '0;
			dollar_q     <= 1'b0;
			xor_q        <= '0;
			ovf_q        <= 1'b0;
			for (int i = 0; i < nsc_pkg::DELAY_DEPTH; i++) begin
				recent_q[i] <= '0;
			end
		end else if (advance && !is_marker) begin
			in_line_q    <= in_line_n;
			byte_count_q <= cnt1;
			dollar_q     <= dollar0;
			xor_q        <= xr_n;
			ovf_q        <= ovf1;
			recent_q     <= rb_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= r_valid;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_kind_q    <= r_kind;
			out_payload_q <= r_payload;
			out_calc_q    <= r_calc;
			out_rcvd_q    <= r_rcvd;
			out_last_q    <= r_last;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.kind              = out_kind_q;
	assign res.payload_byte      = out_payload_q;
	assign res.computed_checksum = out_calc_q;
	assign res.received_checksum = out_rcvd_q;
	assign res.last              = out_last_q;

	a_lf_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 == nsc_pkg::CH_LF |=> !in_line_q)
		else $error("line feed did not close the line");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_line_q |-> byte_count_q != 8'd0)
		else $error("open line with zero byte count");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && out_valid_q && !res.ready)
		else $error("rx stalled without a blocked result");

	a_body_late: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == nsc_pkg::KIND_BODY |->
			in_line_q && byte_count_q >= nsc_pkg::MIN_LINE_LEN)
		else $error("body byte released too early in the line");

endmodule
